/* rtl/core/pix_rld_pkg.sv */
// ----------------------------------------------------------------------------
// pix_rld_pkg
// Shared types and constants of the pixel run-length decoder: transaction
// payloads, result status codes and header layout.
// ----------------------------------------------------------------------------
package pix_rld_pkg;

  // Largest legal width or height is 2^DIM_BITS - 1
  localparam int unsigned DIM_BITS = 15;

  localparam int unsigned IDX_W    = 30;
  localparam int unsigned HDR_W    = 4;
  localparam logic [HDR_W-1:0] HDR_BYTES = HDR_W'(10);

  // Header byte positions
  localparam logic [HDR_W-1:0] HDR_WIDTH_HI  = HDR_W'(0);
  localparam logic [HDR_W-1:0] HDR_WIDTH_LO  = HDR_W'(1);
  localparam logic [HDR_W-1:0] HDR_HEIGHT_HI = HDR_W'(2);
  localparam logic [HDR_W-1:0] HDR_HEIGHT_LO = HDR_W'(3);
  localparam logic [HDR_W-1:0] HDR_DEPTH_HI  = HDR_W'(8);
  localparam logic [HDR_W-1:0] HDR_DEPTH_LO  = HDR_W'(9);

  localparam logic [15:0] DEPTH_GRAY  = 16'd8;
  localparam logic [15:0] DEPTH_COLOR = 16'd24;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_ZERO_COUNT = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             is_gray;
    logic [7:0]       run_length;
    logic [IDX_W-1:0] start_index;
    logic             last_of_image;
  } out_item_t;

endpackage

/* rtl/core/pix_rld_if.sv */
// ----------------------------------------------------------------------------
// pix_rld_if
// Valid/ready stream channels of the decoder: file bytes in, runs out.
// ----------------------------------------------------------------------------
interface pix_rld_in_if
  import pix_rld_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pix_rld_out_if
  import pix_rld_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/pix_run_length_decoder.sv */
// ----------------------------------------------------------------------------
// pix_run_length_decoder
// Parses a 10-byte image header, then decodes count/colour packets into runs
// with clipped length and starting linear pixel index.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                       transaction
//   in_i     in   data_byte, start_of_image                     valid & ready
//   out_o    out  status, red/green/blue, is_gray, run_length,  valid & ready
//                 start_index, last_of_image
//
// One byte per cycle: each byte updates small registers; a byte ending a run
// or an error loads the result register as it is accepted, so a run appears
// in the next cycle. The result register frees in_i.ready whenever it is
// empty or being drained. The pixel total comes from one 16x16 multiply at
// the last header byte. Reset leaves the decoder stopped until a byte with
// start_of_image arrives.
// ----------------------------------------------------------------------------
module pix_run_length_decoder
  import pix_rld_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  pix_rld_in_if.sink    in_i,
  pix_rld_out_if.source out_o
);

  typedef enum logic [3:0] {
    PH_COUNT = 4'b0001,
    PH_FIRST = 4'b0010,
    PH_GREEN = 4'b0100,
    PH_RED   = 4'b1000
  } phase_e;

  logic [HDR_W-1:0] hdr_pos_q, hdr_pos_d;
  logic [15:0]      width_q, width_d;
  logic [15:0]      height_q, height_d;
  logic [15:0]      depth_q, depth_d;
  logic [IDX_W-1:0] remain_q, remain_d;
  logic [IDX_W-1:0] next_idx_q, next_idx_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       count_q, count_d;
  logic [7:0]       blue_q, blue_d;
  logic [7:0]       green_q, green_d;
  logic             stopped_q, stopped_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             accept;
  logic [31:0]      product;
  logic             gray;
  logic [7:0]       run_len;
  logic             run_last;
  logic [15:0]      depth_word;
  logic             bad_header;

  assign accept    = in_i.valid & in_i.ready;
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Pixel total; width and height are settled before the last header byte
  assign product = width_q * height_q;
  assign gray    = (depth_q == DEPTH_GRAY);

  // Clip the pending run against the pixels left in the image
  assign run_len  = (remain_q < IDX_W'(count_q)) ? remain_q[7:0] : count_q;
  assign run_last = (remain_q == IDX_W'(run_len));

  // Header check on the last header byte
  assign depth_word = {depth_q[15:8], in_i.data.data_byte};
  assign bad_header = (width_q == 16'd0) || ((width_q >> DIM_BITS) != 16'd0) ||
                      (height_q == 16'd0) || ((height_q >> DIM_BITS) != 16'd0) ||
                      ((depth_word != DEPTH_GRAY) && (depth_word != DEPTH_COLOR));

  // Decode one byte
  always_comb begin
    logic [7:0] b;
    logic       emit;
    logic       run_done;
    b          = in_i.data.data_byte;
    emit       = 1'b0;
    run_done   = 1'b0;
    hdr_pos_d  = hdr_pos_q;
    width_d    = width_q;
    height_d   = height_q;
    depth_d    = depth_q;
    remain_d   = remain_q;
    next_idx_d = next_idx_q;
    phase_d    = phase_q;
    count_d    = count_q;
    blue_d     = blue_q;
    green_d    = green_q;
    stopped_d  = stopped_q;
    out_d      = out_q;

    if (accept) begin
      // Restart abandons any image in progress
      if (in_i.data.start_of_image) begin
        stopped_d  = 1'b0;
        hdr_pos_d  = '0;
        phase_d    = PH_COUNT;
        next_idx_d = '0;
      end

      if (!stopped_d) begin
        if (hdr_pos_d < HDR_BYTES) begin
          case (hdr_pos_d)
            HDR_WIDTH_HI:  width_d[15:8]  = b;
            HDR_WIDTH_LO:  width_d[7:0]   = b;
            HDR_HEIGHT_HI: height_d[15:8] = b;
            HDR_HEIGHT_LO: height_d[7:0]  = b;
            HDR_DEPTH_HI:  depth_d[15:8]  = b;
            HDR_DEPTH_LO:  depth_d[7:0]   = b;
            default: ;
          endcase
          hdr_pos_d = hdr_pos_d + HDR_W'(1);
          if (hdr_pos_d == HDR_BYTES) begin
            if (bad_header) begin
              stopped_d = 1'b1;
              emit      = 1'b1;
              out_d     = '0;
              out_d.status = STATUS_BAD_HEADER;
            end else begin
              remain_d   = product[IDX_W-1:0];
              next_idx_d = '0;
              phase_d    = PH_COUNT;
            end
          end
        end else begin
          case (phase_d)
            PH_COUNT: begin
              if (b == 8'd0) begin
                stopped_d         = 1'b1;
                emit              = 1'b1;
                out_d             = '0;
                out_d.status      = STATUS_ZERO_COUNT;
                out_d.is_gray     = gray;
                out_d.start_index = next_idx_d;
              end else begin
                count_d = b;
                phase_d = PH_FIRST;
              end
            end
            PH_FIRST: begin
              if (gray) begin
                emit     = 1'b1;
                run_done = 1'b1;
                out_d.red   = 8'd0;
                out_d.green = b;
                out_d.blue  = 8'd0;
              end else begin
                blue_d  = b;
                phase_d = PH_GREEN;
              end
            end
            PH_GREEN: begin
              green_d = b;
              phase_d = PH_RED;
            end
            PH_RED: begin
              emit     = 1'b1;
              run_done = 1'b1;
              out_d.red   = b;
              out_d.green = green_q;
              out_d.blue  = blue_q;
            end
            default: ;
          endcase

          // Finish a run: advance the index and stop at the image end
          if (run_done) begin
            out_d.status        = STATUS_OK;
            out_d.is_gray       = gray;
            out_d.run_length    = run_len;
            out_d.start_index   = next_idx_q;
            out_d.last_of_image = run_last;
            next_idx_d = next_idx_q + IDX_W'(run_len);
            remain_d   = remain_q - IDX_W'(run_len);
            phase_d    = PH_COUNT;
            if (run_last) begin
              stopped_d = 1'b1;
            end
          end
        end
      end
    end

    // Hold the result until taken
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q   <= '0;
      width_q     <= '0;
      height_q    <= '0;
      depth_q     <= '0;
      remain_q    <= '0;
      next_idx_q  <= '0;
      phase_q     <= PH_COUNT;
      count_q     <= '0;
      blue_q      <= '0;
      green_q     <= '0;
      stopped_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      hdr_pos_q   <= hdr_pos_d;
      width_q     <= width_d;
      height_q    <= height_d;
      depth_q     <= depth_d;
      remain_q    <= remain_d;
      next_idx_q  <= next_idx_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      blue_q      <= blue_d;
      green_q     <= green_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
